FILE: rtl/core/rsam_pkg.sv
`default_nettype none

package rsam_pkg;

  // Largest array the mapper accepts; disk numbers are four bits wide.
  localparam logic [4:0] MaxDisks = 5'd16;

  typedef enum logic [1:0] {
    LvlStripe    = 2'd0,
    LvlMirror    = 2'd1,
    LvlDedParity = 2'd2,
    LvlRotParity = 2'd3
  } raid_level_e;

  // Register indexes, taken from paddr[2].
  localparam logic RegRaidLevel = 1'b0;
  localparam logic RegDiskCount = 1'b1;

  // Control and running remainders carried from cell to cell.
  typedef struct packed {
    raid_level_e level;
    logic [4:0]  disks;    // configured disk count
    logic [4:0]  divisor;  // disks, pairs or data disks per row
    logic        err;
    logic [4:0]  rem;      // partial remainder of the stripe number
    logic [4:0]  rem2;     // running quotient modulo the disk count
  } ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/rsam_cell.sv
`default_nettype none

module rsam_cell #(
  parameter int W = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  rsam_pkg::ctrl_t     in_ctrl_i,
  input  wire [W-1:0]         in_acc_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output rsam_pkg::ctrl_t     out_ctrl_o,
  output logic [W-1:0]        out_acc_o
);
  import rsam_pkg::*;

  logic       valid_q;
  ctrl_t      ctrl_d, ctrl_q;
  logic [W-1:0] acc_d, acc_q;
  logic [5:0] t, t2;
  logic       ge, ge2;

  // One restoring-division step. The quotient bit is shifted into the low end
  // of the accumulator and also folded into the quotient modulo the disk count.
  always_comb begin
    t      = {in_ctrl_i.rem, in_acc_i[W-1]};
    ge     = t >= {1'b0, in_ctrl_i.divisor};
    t2     = {in_ctrl_i.rem2, ge};
    ge2    = t2 >= {1'b0, in_ctrl_i.disks};
    ctrl_d = in_ctrl_i;
    ctrl_d.rem  = ge  ? 5'(t - {1'b0, in_ctrl_i.divisor}) : t[4:0];
    ctrl_d.rem2 = ge2 ? 5'(t2 - {1'b0, in_ctrl_i.disks}) : t2[4:0];
    acc_d  = {in_acc_i[W-2:0], ge};
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ctrl_q <= ctrl_d;
      acc_q  <= acc_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_ctrl_o  = ctrl_q;
  assign out_acc_o   = acc_q;

endmodule

`default_nettype wire

FILE: rtl/core/rsam_output.sv
`default_nettype none

module rsam_output #(
  parameter int W           = 32,
  parameter int BLOCK_BYTES = 4096
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  rsam_pkg::ctrl_t     in_ctrl_i,
  input  wire [W-1:0]         in_acc_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [95:0]         out_data_o,
  output logic                out_error_o
);
  import rsam_pkg::*;

  localparam int BbW = $clog2(BLOCK_BYTES + 1);
  localparam logic [BbW-1:0] Bb = BbW'(BLOCK_BYTES);

  logic            valid_q;
  logic [95:0]     data_d, data_q;
  logic            err_q;
  logic [31:0]     row32;
  logic [31+BbW:0] prod;
  logic [3:0]      data_disk, mirror_disk, parity_disk, idx;
  logic            mirror_valid, parity_valid;
  logic [4:0]      parity5;

  if (W >= 32) begin : g_row_trunc
    assign row32 = in_acc_i[31:0];
  end else begin : g_row_ext
    assign row32 = {{(32 - W){1'b0}}, in_acc_i};
  end

  assign prod = {{BbW{1'b0}}, row32} * {32'd0, Bb};

  always_comb begin
    idx          = in_ctrl_i.rem[3:0];
    data_disk    = 4'd0;
    mirror_disk  = 4'd0;
    mirror_valid = 1'b0;
    parity_disk  = 4'd0;
    parity_valid = 1'b0;
    parity5      = 5'(in_ctrl_i.disks - 5'd1 - in_ctrl_i.rem2);
    unique case (in_ctrl_i.level)
      LvlStripe: begin
        data_disk = idx;
      end
      LvlMirror: begin
        data_disk    = {idx[2:0], 1'b0};
        mirror_disk  = {idx[2:0], 1'b1};
        mirror_valid = 1'b1;
      end
      LvlDedParity: begin
        data_disk    = idx;
        parity_disk  = 4'(in_ctrl_i.disks - 5'd1);
        parity_valid = 1'b1;
      end
      default: begin
        // Rotating parity: data at or past the parity disk moves one disk up.
        parity_disk  = parity5[3:0];
        data_disk    = ({1'b0, idx} < parity5) ? idx : 4'(idx + 4'd1);
        parity_valid = 1'b1;
      end
    endcase
    data_d = {6'd0, 44'(prod), row32, parity_valid, parity_disk,
              mirror_valid, mirror_disk, data_disk};
    if (in_ctrl_i.err) begin
      data_d = '0;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
      err_q  <= in_ctrl_i.err;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_error_o = err_q;

endmodule

`default_nettype wire

FILE: rtl/core/raid_stripe_address_mapper.sv
`default_nettype none

// RAID stripe address mapper. Each stripe number taken on the slave stream
// yields one placement item on the master stream: data disk, mirror or parity
// disk with their valid flags, the row on each member disk and the byte offset
// of that row. The quotient and remainder by the per-level divisor (disk count,
// pair count or data-disk count) come from a chain of STRIPE_BITS division
// cells, one quotient bit per cell, followed by one output stage. One item is
// taken every cycle unless a stalled result has filled the chain; the cells
// collapse bubbles, so a stalled result only blocks new items once every cell
// is full. Configuration must be written over APB only while no item is in
// flight; the block does not enforce this. An unusable disk count for the
// chosen level gives results with config_error set and all other fields zero.
module raid_stripe_address_mapper #(
  parameter int STRIPE_BITS = 32,
  parameter int BLOCK_BYTES = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // APB configuration port: raid_level at 0x0, disk_count at 0x4.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream. tdata: stripe_number[31:0].
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,
  // Output stream. tdata: data_disk[3:0], mirror_disk[7:4], mirror_valid[8],
  // parity_disk[12:9], parity_valid[13], block_row[45:14],
  // byte_offset[89:46], zero fill[95:90].
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [95:0] m_axis_tdata,
  // tuser: config_error[0].
  output logic        m_axis_tuser
);
  import rsam_pkg::*;

  localparam int N = STRIPE_BITS;

  raid_level_e level_q;
  logic [4:0]  disks_q;

  // ---------------------------------------------------------------------------
  // Configuration registers. Only paddr[2] selects the register.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LvlStripe;
      disks_q <= 5'd2;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        RegRaidLevel: level_q <= raid_level_e'(pwdata[1:0]);
        RegDiskCount: disks_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegRaidLevel: prdata = {30'd0, level_q};
      RegDiskCount: prdata = {27'd0, disks_q};
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Validity check and divisor selection, applied as an item enters the chain.
  // ---------------------------------------------------------------------------
  logic  cfg_err;
  ctrl_t head_ctrl;

  always_comb begin
    unique case (level_q)
      LvlStripe: cfg_err = disks_q < 5'd2;
      LvlMirror: cfg_err = (disks_q < 5'd2) || disks_q[0];
      default:   cfg_err = disks_q < 5'd3;
    endcase
    if ((disks_q > MaxDisks) || (disks_q > 5'd16)) begin
      cfg_err = 1'b1;
    end

    head_ctrl.level = level_q;
    head_ctrl.err   = cfg_err;
    head_ctrl.rem   = 5'd0;
    head_ctrl.rem2  = 5'd0;
    head_ctrl.disks = disks_q;
    unique case (level_q)
      LvlStripe: head_ctrl.divisor = disks_q;
      LvlMirror: head_ctrl.divisor = {1'b0, disks_q[4:1]};
      default:   head_ctrl.divisor = 5'(disks_q - 5'd1);
    endcase
    // A rejected configuration still runs through the chain; keep it harmless.
    if (cfg_err) begin
      head_ctrl.divisor = 5'd1;
      head_ctrl.disks   = 5'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // Division chain.
  // ---------------------------------------------------------------------------
  logic         valid_s [0:N];
  logic         ready_s [0:N];
  ctrl_t        ctrl_s  [0:N];
  logic [N-1:0] acc_s   [0:N];

  if (N > 32) begin : g_in_ext
    assign acc_s[0] = {{(N - 32){1'b0}}, s_axis_tdata};
  end else begin : g_in_trunc
    assign acc_s[0] = s_axis_tdata[N-1:0];
  end

  assign valid_s[0]    = s_axis_tvalid;
  assign ctrl_s[0]     = head_ctrl;
  assign s_axis_tready = ready_s[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    rsam_cell #(
      .W (N)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_s[i]),
      .in_ready_o  (ready_s[i]),
      .in_ctrl_i   (ctrl_s[i]),
      .in_acc_i    (acc_s[i]),
      .out_valid_o (valid_s[i+1]),
      .out_ready_i (ready_s[i+1]),
      .out_ctrl_o  (ctrl_s[i+1]),
      .out_acc_o   (acc_s[i+1])
    );
  end

  rsam_output #(
    .W           (N),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_output (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_s[N]),
    .in_ready_o  (ready_s[N]),
    .in_ctrl_i   (ctrl_s[N]),
    .in_acc_i    (acc_s[N]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_error_o (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The input side only stalls when a result is held up at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output stall");

  // An error result carries no placement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 96'd0))
    else $error("error result with nonzero fields");

  // A mirror pair is an even disk and the one after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |->
      (!m_axis_tdata[0] && (m_axis_tdata[7:4] == (m_axis_tdata[3:0] | 4'd1))))
    else $error("mirror disk is not the partner of the data disk");

  // Data never lands on the parity disk of its row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[13]) |-> (m_axis_tdata[3:0] != m_axis_tdata[12:9]))
    else $error("data disk equals parity disk");

endmodule

`default_nettype wire

FILE: dv/tb_raid_stripe_address_mapper.sv
`default_nettype none

// Testbench for the RAID stripe address mapper.
//
// A driver process feeds stripe numbers from a queue into the slave stream in
// bursts with random gaps. At each accepted item it works out the placement
// that the block must produce, using its own copy of the array settings, and
// appends it to a queue of expected placements. A monitor process takes every
// item from the master stream and compares it field by field with the oldest
// expected placement. The receiver drops tready on patterns that change over
// time, and now and then holds off long enough for the division pipeline to
// fill up and push back on the input.
//
// The array settings are only changed over APB once the block is empty: every
// stripe number has been sent and every expected placement has come back.
module tb_raid_stripe_address_mapper;
  import rsam_pkg::*;

  localparam int StripeBits = 32;
  localparam int BlockBytes = 4096;
  // The division chain plus the output stage.
  localparam int PipeDepth  = StripeBits + 1;
  localparam int CycleLimit = 1_000_000;

  // Expected placement of one stripe, one member per output field.
  typedef struct packed {
    logic [3:0]  data_disk;
    logic [3:0]  mirror_disk;
    logic        mirror_valid;
    logic [3:0]  parity_disk;
    logic        parity_valid;
    logic [31:0] block_row;
    logic [43:0] byte_offset;
    logic        config_error;
  } placement_t;

  // The receiver switches between these tready patterns.
  typedef enum logic [1:0] {
    RdyOpen,    // always ready
    RdyCoin,    // ready half of the time
    RdySparse,  // ready with a chance of one in eight
    RdyBeat     // low whenever the beat count is a multiple of four
  } ready_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // stripe_number[31:0]

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // data_disk[3:0], mirror_disk[7:4], mirror_valid[8], parity_disk[12:9],
  // parity_valid[13], block_row[45:14], byte_offset[89:46], zero fill[95:90]
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;        // config_error[0]

  // Our copy of the two configuration registers, updated on every APB write.
  raid_level_e cur_level = LvlStripe;
  logic [4:0]  cur_disks = 5'd2;

  logic [31:0] stripe_q[$];      // stripe numbers waiting to be sent
  placement_t  placement_q[$];   // placements still owed by the block

  int fail_count = 0;
  int cycle_count = 0;

  // Sender pacing.
  int burst_left = 1;
  int gap_left = 0;

  // Receiver pacing. The stimulus asks for a long hold-off by bumping
  // hold_trips; the receiver notices the change and counts the stall itself.
  int          hold_trips = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  int          beat_count = 0;
  ready_mode_e rdy_mode = RdyOpen;

  placement_t seen_pl;
  placement_t want_pl;

  raid_stripe_address_mapper #(
    .STRIPE_BITS(StripeBits),
    .BLOCK_BYTES(BlockBytes)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Works out where a stripe lands for a given level and disk count. An
  // unusable disk count yields only the error flag. Mirrored pairs put the
  // primary on the even disk of a pair and the mirror right after it. With
  // rotating parity the parity disk walks down by one per row and wraps, and
  // data at or past the parity disk moves one disk to the right.
  function automatic placement_t map_stripe(raid_level_e lvl, logic [4:0] disks,
                                            logic [31:0] stripe);
    placement_t  p;
    logic [63:0] n, d, k, idx, row, par, off;
    logic        usable;
    p = '0;
    n = 64'(stripe);
    d = 64'(disks);
    row = '0;
    case (lvl)
      LvlStripe: usable = (d >= 2);
      LvlMirror: usable = (d >= 2) && !d[0];
      default:   usable = (d >= 3);
    endcase
    if (d > 64'(MaxDisks) || d > 16) usable = 1'b0;
    if (!usable) begin
      p.config_error = 1'b1;
    end else if (lvl == LvlStripe) begin
      p.data_disk = 4'(n % d);
      row = n / d;
    end else if (lvl == LvlMirror) begin
      k = d / 2;
      idx = (n % k) * 2;
      p.data_disk = 4'(idx);
      p.mirror_disk = 4'(idx + 1);
      p.mirror_valid = 1'b1;
      row = n / k;
    end else begin
      k = d - 1;
      idx = n % k;
      row = n / k;
      if (lvl == LvlDedParity) begin
        par = d - 1;
        p.data_disk = 4'(idx);
      end else begin
        par = (d - 1) - (row % d);
        p.data_disk = (idx < par) ? 4'(idx) : 4'(idx + 1);
      end
      p.parity_disk = 4'(par);
      p.parity_valid = 1'b1;
    end
    p.block_row = row[31:0];
    off = 64'(row[31:0]) * 64'(BlockBytes);
    p.byte_offset = off[43:0];
    return p;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // One APB write: a setup phase, then an access phase held until pready.
  // The register takes the value at the edge that completes the access, so
  // our copy is updated right after it.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == RegRaidLevel) cur_level = raid_level_e'(data[1:0]);
    else cur_disks = data[4:0];
  endtask

  // Blocks until the sender has nothing left and every placement is back.
  task automatic wait_idle();
    while (stripe_q.size() != 0 || s_axis_tvalid || placement_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Reconfigures the array once it is empty. Both words may carry junk above
  // the register width; the block keeps only the low bits.
  task automatic set_array(input logic [31:0] level_word, input logic [31:0] disks_word);
    wait_idle();
    if ($urandom_range(0, 1) == 0) begin
      apb_write({RegRaidLevel, 2'b00}, level_word);
      apb_write({RegDiskCount, 2'b00}, disks_word);
    end else begin
      apb_write({RegDiskCount, 2'b00}, disks_word);
      apb_write({RegRaidLevel, 2'b00}, level_word);
    end
  endtask

  // Sender. The expected placement is worked out at the edge where the item
  // is taken; tvalid only drops after a handshake or while it is already low.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        placement_q.push_back(map_stripe(cur_level, cur_disks, s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (stripe_q.size() != 0) begin
          s_axis_tdata <= stripe_q.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            // End of a burst: pick the next one and the pause before it.
            // A third of the bursts follow on with no pause at all.
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. A requested hold-off wins; otherwise the tready pattern is
  // redrawn whenever its mode counter runs out.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_trips) begin
      hold_seen = hold_trips;
      hold_left = $urandom_range(200, 400);
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode = ready_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      beat_count++;
      case (rdy_mode)
        RdyOpen:   m_axis_tready <= 1'b1;
        RdyCoin:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RdySparse: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default:   m_axis_tready <= (beat_count % 4 != 0);
      endcase
    end
  end

  // Monitor. Every item taken on the master stream must match the oldest
  // expected placement in every field.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_pl.data_disk    = m_axis_tdata[3:0];
      seen_pl.mirror_disk  = m_axis_tdata[7:4];
      seen_pl.mirror_valid = m_axis_tdata[8];
      seen_pl.parity_disk  = m_axis_tdata[12:9];
      seen_pl.parity_valid = m_axis_tdata[13];
      seen_pl.block_row    = m_axis_tdata[45:14];
      seen_pl.byte_offset  = m_axis_tdata[89:46];
      seen_pl.config_error = m_axis_tuser;
      if (placement_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got 0x%0h user %0b", $time,
                 m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want_pl = placement_q.pop_front();
        check_field("data_disk", 64'(want_pl.data_disk), 64'(seen_pl.data_disk));
        check_field("mirror_disk", 64'(want_pl.mirror_disk), 64'(seen_pl.mirror_disk));
        check_field("mirror_valid", 64'(want_pl.mirror_valid), 64'(seen_pl.mirror_valid));
        check_field("parity_disk", 64'(want_pl.parity_disk), 64'(seen_pl.parity_disk));
        check_field("parity_valid", 64'(want_pl.parity_valid), 64'(seen_pl.parity_valid));
        check_field("block_row", 64'(want_pl.block_row), 64'(seen_pl.block_row));
        check_field("byte_offset", 64'(want_pl.byte_offset), 64'(seen_pl.byte_offset));
        check_field("config_error", 64'(want_pl.config_error), 64'(seen_pl.config_error));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("raid_stripe_address_mapper verification failed");
      $finish;
    end
  end

  // Stimulus: a directed pass over the corner cases, then random arrays with
  // random stripe numbers.
  initial begin
    raid_level_e lvl;
    logic [4:0]  disks;
    logic [4:0]  lowest;
    logic [31:0] level_word;
    logic [31:0] disks_word;
    logic [31:0] stripe;
    int          item_total;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: striping over two disks, untouched by any write.
    stripe_q = '{32'd0, 32'd5, 32'hFFFF_FFFF};
    // Eight mirrored pairs, including the largest stripe number.
    set_array(32'(LvlMirror), 32'd16);
    stripe_q = '{32'd0, 32'd9, 32'hFFFF_FFFF};
    // Smallest parity array: two data disks and a fixed parity disk.
    set_array(32'(LvlDedParity), 32'd3);
    stripe_q = '{32'd1, 32'd2, 32'hFFFF_FFFF};
    // Rotating parity on sixteen disks: row 15 puts parity on disk 0 and
    // row 16 wraps it back to the last disk.
    set_array(32'(LvlRotParity), 32'd16);
    stripe_q = '{32'd14, 32'd225, 32'd240, 32'hFFFF_FFFF};
    // Rotating parity on three disks, where data skips over the parity disk.
    set_array(32'(LvlRotParity), 32'd3);
    stripe_q = '{32'd0, 32'd1, 32'd2, 32'd3};
    // Words with junk above the register widths: level 0 and sixteen disks.
    set_array(32'hFFFF_FFFC, 32'hFFFF_FFF0);
    stripe_q = '{32'hFFFF_FFFF};
    // Disk counts that the chosen level cannot use.
    set_array(32'(LvlStripe), 32'd1);
    stripe_q = '{32'd7};
    set_array(32'(LvlMirror), 32'd5);
    stripe_q = '{32'd7};
    set_array(32'(LvlDedParity), 32'd2);
    stripe_q = '{32'd7};
    set_array(32'(LvlRotParity), 32'd17);
    stripe_q = '{32'hFFFF_FFFF};
    set_array(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    stripe_q = '{32'd1};
    set_array(32'(LvlStripe), 32'd0);
    stripe_q = '{32'd1};

    // Random arrays. Most disk counts suit the level; the smallest and the
    // largest usable counts and any five-bit count also turn up.
    for (int ph = 0; ph < 40; ph++) begin
      lvl = raid_level_e'($urandom_range(0, 3));
      lowest = (lvl == LvlStripe || lvl == LvlMirror) ? 5'd2 : 5'd3;
      case ($urandom_range(0, 9))
        0, 1: disks = 5'($urandom_range(0, 31));
        2:    disks = ($urandom_range(0, 1) == 0) ? lowest : 5'd16;
        default: begin
          if (lvl == LvlMirror) disks = 5'(2 * $urandom_range(1, 8));
          else disks = 5'($urandom_range(lowest, 16));
        end
      endcase
      level_word = 32'(lvl);
      disks_word = 32'(disks);
      if ($urandom_range(0, 3) == 0) begin
        level_word = ($urandom() & ~32'h3) | level_word;
        disks_word = ($urandom() & ~32'h1F) | disks_word;
      end
      set_array(level_word, disks_word);

      // A few phases start with the receiver holding off while a long run of
      // items is offered, so the pipeline fills and the input stalls.
      item_total = 40;
      if (ph % 13 == 6) begin
        item_total = 90;
        hold_trips++;
      end
      for (int i = 0; i < item_total; i++) begin
        case ($urandom_range(0, 4))
          0:       stripe = 32'($urandom_range(0, 600));
          1:       stripe = 32'hFFFF_FFFF - 32'($urandom_range(0, 600));
          2: begin
            stripe = 32'h1 << $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 0) stripe = ~stripe;
          end
          default: stripe = $urandom();
        endcase
        stripe_q.push_back(stripe);
      end
    end

    wait_idle();
    repeat (2 * PipeDepth) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("raid_stripe_address_mapper verification clean");
    end else begin
      $display("raid_stripe_address_mapper verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
